@@ src/astt_pkg.sv @@
package astt_pkg;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;
    localparam logic [7:0] COLUMNS_RESET = 8'd128;
    localparam logic [7:0] ROWS_RESET    = 8'd48;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Attribute constants
    localparam logic [7:0] ATTR_DEFAULT = 8'h07;
    localparam logic [7:0] ATTR_BRIGHT  = 8'h08;

    // Byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;

    // Tab stops every four columns
    localparam logic [2:0] TAB_STOP = 3'd4;

    typedef enum logic [1:0] {
        PM_TEXT = 2'd0,
        PM_ESC  = 2'd1,
        PM_CSI  = 2'd2
    } t_parse_mode;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    // One classified byte: scrolls first, then cells, then the report
    typedef struct packed {
        logic [1:0] nscroll;
        logic [2:0] ncells;
        logic [7:0] glyph;
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic [3:0] fore;
        logic [3:0] back;
        logic [7:0] rep_col;
        logic [7:0] rep_row;
    } t_cmd;

    // Normal foreground palette
    function automatic logic [3:0] fg_normal(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0: v = 4'd0;
            3'd1: v = 4'd4;
            3'd2: v = 4'd2;
            3'd3: v = 4'd6;
            3'd4: v = 4'd1;
            3'd5: v = 4'd5;
            3'd6: v = 4'd3;
            default: v = 4'd7;
        endcase
        return v;
    endfunction

    // Normal background palette (yellow maps to bright yellow)
    function automatic logic [3:0] bg_normal(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0: v = 4'd0;
            3'd1: v = 4'd4;
            3'd2: v = 4'd2;
            3'd3: v = 4'd14;
            3'd4: v = 4'd1;
            3'd5: v = 4'd5;
            3'd6: v = 4'd3;
            default: v = 4'd7;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] bright(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0: v = 4'd8;
            3'd1: v = 4'd12;
            3'd2: v = 4'd10;
            3'd3: v = 4'd14;
            3'd4: v = 4'd9;
            3'd5: v = 4'd13;
            3'd6: v = 4'd11;
            default: v = 4'd15;
        endcase
        return v;
    endfunction

    // SGR code applied to the attribute; unknown codes leave it alone
    function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [7:0] code);
        logic [3:0] fg;
        logic [3:0] bg;
        logic [7:0] res;
        logic [7:0] off30;
        logic [7:0] off90;
        logic [7:0] off40;
        logic [7:0] off100;
        fg     = attr[3:0];
        bg     = attr[7:4];
        res    = attr;
        off30  = code - 8'd30;
        off90  = code - 8'd90;
        off40  = code - 8'd40;
        off100 = code - 8'd100;
        if (code == 8'd0 || code == 8'd28) begin
            res = ATTR_DEFAULT;
        end else if (code == 8'd1 || code == 8'd22) begin
            if (attr < ATTR_BRIGHT) res = attr + ATTR_BRIGHT;
        end else if (code == 8'd2 || code == 8'd21) begin
            if (attr > ATTR_BRIGHT) res = attr - ATTR_BRIGHT;
        end else if (code == 8'd7 || code == 8'd27) begin
            res = {fg, bg};
        end else if (code == 8'd8) begin
            res = {bg, bg};
        end else if (code >= 8'd30 && code <= 8'd37) begin
            res = {bg, fg_normal(off30[2:0])};
        end else if (code == 8'd39) begin
            res = {bg, 4'd7};
        end else if (code >= 8'd90 && code <= 8'd97) begin
            res = {bg, bright(off90[2:0])};
        end else if (code >= 8'd40 && code <= 8'd47) begin
            res = {bg_normal(off40[2:0]), fg};
        end else if (code == 8'd49) begin
            res = {4'd0, fg};
        end else if (code >= 8'd100 && code <= 8'd107) begin
            res = {bright(off100[2:0]), fg};
        end
        return res;
    endfunction

endpackage

@@ src/astt_in_if.sv @@
interface astt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

@@ src/astt_out_if.sv @@
interface astt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] glyph;
    logic [7:0] col;
    logic [7:0] row;
    logic [3:0] fore;
    logic [3:0] back;
    logic       last;

    modport source (output valid, output kind, output glyph, output col, output row,
                    output fore, output back, output last, input ready);
    modport sink   (input valid, input kind, input glyph, input col, input row,
                    input fore, input back, input last, output ready);
endinterface

@@ src/astt_front.sv @@
module astt_front import astt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    astt_in_if.sink              i_in,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [7:0]  r_columns;
    logic [7:0]  r_rows;
    logic [7:0]  r_col, n_col;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_attr, n_attr;
    t_parse_mode r_mode, n_mode;
    logic [7:0]  r_num, n_num;
    logic        r_done, n_done;

    logic        accept;
    logic [7:0]  c;
    logic        wrap;
    logic        w_scroll;
    logic [7:0]  w_col;
    logic [7:0]  w_row;
    logic        nl_scroll;
    logic [11:0] num_wide;
    logic [7:0]  digit;
    logic        is_digit;
    t_cmd        cmd;

    assign c        = i_in.text_byte;
    assign i_in.ready = !i_q_full;
    assign accept   = i_in.valid && !i_q_full;
    assign o_push   = accept;
    assign o_cmd    = cmd;

    // Decimal accumulator, saturating at 255
    assign digit    = c - CH_ZERO;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign num_wide = {4'd0, r_num} * 12'd10 + {4'd0, digit};

    // Wrap check ahead of any printed byte
    always_comb begin
        wrap     = ({1'b0, r_col} + 9'd1) >= {1'b0, r_columns};
        w_scroll = 1'b0;
        w_col    = r_col;
        w_row    = r_row;
        if (wrap) begin
            w_col = 8'd0;
            if (r_row < r_rows) begin
                w_row = r_row + 8'd1;
            end else begin
                w_scroll = 1'b1;
                w_row    = r_rows;
            end
        end
    end

    // Parser and cursor rules
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_attr    = r_attr;
        n_mode    = r_mode;
        n_num     = r_num;
        n_done    = r_done;
        nl_scroll = 1'b0;
        cmd       = '0;
        cmd.fore  = r_attr[3:0];
        cmd.back  = r_attr[7:4];
        case (r_mode)
            PM_ESC: begin
                if (c == CH_LBRACK) begin
                    n_mode = PM_CSI;
                    n_num  = 8'd0;
                    n_done = 1'b0;
                end else begin
                    n_mode = PM_TEXT;
                end
            end
            PM_CSI: begin
                if (c == CH_M) begin
                    n_attr = sgr_apply(r_attr, r_num);
                    n_mode = PM_TEXT;
                end else if (!r_done && is_digit) begin
                    n_num = (num_wide > 12'd255) ? 8'd255 : num_wide[7:0];
                end else begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_mode = PM_TEXT;
                if (c == CH_ESC) begin
                    n_mode = PM_ESC;
                end else if (c != CH_NUL) begin
                    n_col        = w_col;
                    n_row        = w_row;
                    cmd.cell_col = w_col;
                    cmd.cell_row = w_row;
                    if (c == CH_NL) begin
                        if (w_row >= r_rows) begin
                            nl_scroll = 1'b1;
                            n_row     = r_rows;
                        end else begin
                            n_row = w_row + 8'd1;
                        end
                        n_col = 8'd0;
                    end else if (c == CH_CR) begin
                        n_col = 8'd0;
                    end else if (c == CH_BS) begin
                        cmd.ncells = 3'd1;
                        cmd.glyph  = CH_SPACE;
                        if (w_col == 8'd0) begin
                            if (w_row > 8'd0) n_row = w_row - 8'd1;
                        end else begin
                            n_col = w_col - 8'd1;
                        end
                    end else if (c == CH_TAB) begin
                        cmd.ncells = TAB_STOP - {1'b0, w_col[1:0]};
                        cmd.glyph  = CH_SPACE;
                        n_col      = w_col + {5'd0, cmd.ncells};
                    end else begin
                        cmd.ncells = 3'd1;
                        cmd.glyph  = c;
                        n_col      = w_col + 8'd1;
                    end
                end
            end
        endcase
        cmd.nscroll = (r_mode != PM_ESC && r_mode != PM_CSI && c != CH_ESC && c != CH_NUL)
                    ? ({1'b0, w_scroll} + {1'b0, nl_scroll}) : 2'd0;
        cmd.rep_col = n_col;
        cmd.rep_row = n_row;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_columns <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Terminal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 8'd0;
            r_row  <= 8'd0;
            r_attr <= ATTR_DEFAULT;
            r_mode <= PM_TEXT;
            r_num  <= 8'd0;
            r_done <= 1'b0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_attr <= n_attr;
            r_mode <= n_mode;
            r_num  <= n_num;
            r_done <= n_done;
        end
    end

endmodule

@@ src/astt_queue.sv @@
module astt_queue import astt_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
            if (do_pop)  r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ src/astt_back.sv @@
module astt_back import astt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_data,
    output logic       o_pop,
    astt_out_if.source o_out
);

    logic       r_busy;
    t_cmd       r_work;
    logic       r_o_valid;
    t_kind      r_o_kind;
    logic [7:0] r_o_glyph;
    logic [7:0] r_o_col;
    logic [7:0] r_o_row;
    logic [3:0] r_o_fore;
    logic [3:0] r_o_back;
    logic       r_o_last;

    logic       load;
    logic       emit;
    logic       is_report;

    assign load      = !r_o_valid || o_out.ready;
    assign emit      = r_busy && load;
    assign is_report = (r_work.nscroll == 2'd0) && (r_work.ncells == 3'd0);
    assign o_pop     = i_q_valid && (!r_busy || (emit && is_report));

    assign o_out.valid = r_o_valid;
    assign o_out.kind  = r_o_kind;
    assign o_out.glyph = r_o_glyph;
    assign o_out.col   = r_o_col;
    assign o_out.row   = r_o_row;
    assign o_out.fore  = r_o_fore;
    assign o_out.back  = r_o_back;
    assign o_out.last  = r_o_last;

    // Working command: take the next one as the report goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && is_report) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_q_data;
        end else if (emit) begin
            if (r_work.nscroll != 2'd0) begin
                r_work.nscroll <= r_work.nscroll - 2'd1;
            end else if (r_work.ncells != 3'd0) begin
                r_work.ncells   <= r_work.ncells - 3'd1;
                r_work.cell_col <= r_work.cell_col + 8'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_glyph <= 8'd0;
            r_o_col   <= 8'd0;
            r_o_row   <= 8'd0;
            r_o_fore  <= 4'd0;
            r_o_back  <= 4'd0;
            r_o_last  <= 1'b0;
            if (r_work.nscroll != 2'd0) begin
                r_o_kind <= KIND_SCROLL;
            end else if (r_work.ncells != 3'd0) begin
                r_o_kind  <= KIND_CELL;
                r_o_glyph <= r_work.glyph;
                r_o_col   <= r_work.cell_col;
                r_o_row   <= r_work.cell_row;
                r_o_fore  <= r_work.fore;
                r_o_back  <= r_work.back;
            end else begin
                r_o_kind <= KIND_REPORT;
                r_o_col  <= r_work.rep_col;
                r_o_row  <= r_work.rep_row;
                r_o_last <= 1'b1;
            end
        end
    end

endmodule

@@ src/ansi_sgr_text_terminal_unit.sv @@
// Text terminal with cursor rules and SGR color escapes.
// Results pass through the command queue, the working command and the output register.
// One byte accepted per cycle while the command queue has room; the back end sends one
// result per cycle while the output is ready; a byte makes 1 to 6 results (tab most).
// Reset (synchronous, active low): cursor 0,0, attribute 0x07, parser idle, width 128,
// last row 48, queue and output emptied.
module ansi_sgr_text_terminal_unit import astt_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    astt_in_if.sink              i_in,
    astt_out_if.source           o_out
);

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_cmd cmd_in;
    t_cmd cmd_out;

    astt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (full),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    astt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (cmd_out)
    );

    astt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (cmd_out),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ tb/sv/ansi_sgr_text_terminal_unit_tb.sv @@
module ansi_sgr_text_terminal_unit_tb;
    import astt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int QUIET_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 100;
    localparam int NUM_PHASES     = 7;

    // Palettes, entry 0 in the low nibble
    localparam logic [31:0] FG_PAL     = 32'h7351_6240;
    localparam logic [31:0] BG_PAL     = 32'h7351_E240;
    localparam logic [31:0] BRIGHT_PAL = 32'hFBD9_EAC8;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] glyph;
        logic [7:0] col;
        logic [7:0] row;
        logic [3:0] fore;
        logic [3:0] back;
        logic       last;
    } t_term_event;

    // Directed row: byte, and the cursor report typed in where it is obvious
    typedef struct packed {
        logic [7:0] text;
        logic       typed;
        logic [7:0] col;
        logic [7:0] row;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        '{CH_NUL,    1'b1, 8'd0, 8'd0},  // nothing printed
        '{8'h41,     1'b1, 8'd1, 8'd0},
        '{8'hFF,     1'b1, 8'd2, 8'd0},
        '{CH_TAB,    1'b1, 8'd4, 8'd0},  // two erased cells
        '{CH_TAB,    1'b1, 8'd8, 8'd0},  // full four cells
        '{CH_BS,     1'b1, 8'd7, 8'd0},
        '{CH_CR,     1'b1, 8'd0, 8'd0},
        '{CH_BS,     1'b1, 8'd0, 8'd0},  // home: erase, no move
        '{CH_NL,     1'b1, 8'd0, 8'd1},
        '{CH_BS,     1'b1, 8'd0, 8'd0},  // column 0: row goes up
        '{CH_ESC,    1'b1, 8'd0, 8'd0},
        '{8'h78,     1'b1, 8'd0, 8'd0},  // dropped after ESC
        '{CH_ESC,    1'b0, 8'd0, 8'd0},
        '{CH_LBRACK, 1'b0, 8'd0, 8'd0},
        '{CH_NINE,   1'b0, 8'd0, 8'd0},
        '{CH_NINE,   1'b0, 8'd0, 8'd0},
        '{CH_NINE,   1'b0, 8'd0, 8'd0},  // number saturates
        '{8'h3B,     1'b0, 8'd0, 8'd0},  // ends the number
        '{CH_M,      1'b1, 8'd0, 8'd0},  // unknown code, no change
        '{CH_ESC,    1'b0, 8'd0, 8'd0},
        '{CH_LBRACK, 1'b0, 8'd0, 8'd0},
        '{8'h34,     1'b0, 8'd0, 8'd0},
        '{8'h31,     1'b0, 8'd0, 8'd0},
        '{CH_M,      1'b1, 8'd0, 8'd0},  // red background
        '{8'h5A,     1'b1, 8'd1, 8'd0}
    };

    // Geometry and length of each random phase
    int ph_cols  [NUM_PHASES] = '{5, 2, 255, 0, 1, 12, 3};
    int ph_rows  [NUM_PHASES] = '{3, 1, 254, 0, 255, 6, 2};
    int ph_items [NUM_PHASES] = '{45, 35, 25, 35, 35, 45, 45};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    astt_in_if  in_if ();
    astt_out_if out_if ();

    ansi_sgr_text_terminal_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Terminal state as predicted
    logic [7:0]  term_cols;
    logic [7:0]  term_rows;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [7:0]  cur_attr;
    logic [7:0]  sgr_acc;
    logic        num_closed;
    t_parse_mode parse_st;

    t_term_event term_events_q [$];

    bit idle_en     = 1'b1;
    int hold_len    = 0;
    int bytes_sent  = 0;
    int geometries  = 1;
    int mismatches  = 0;
    int cells_seen  = 0;
    int scrolls_seen = 0;
    int reports_seen = 0;
    int stuck_cycles = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void term_reset();
        term_cols  = COLUMNS_RESET;
        term_rows  = ROWS_RESET;
        cur_col    = 8'd0;
        cur_row    = 8'd0;
        cur_attr   = ATTR_DEFAULT;
        sgr_acc    = 8'd0;
        num_closed = 1'b0;
        parse_st   = PM_TEXT;
    endfunction

    function automatic void push_cell(input logic [7:0] g);
        t_term_event ev;
        ev       = '0;
        ev.kind  = KIND_CELL;
        ev.glyph = g;
        ev.col   = cur_col;
        ev.row   = cur_row;
        ev.fore  = cur_attr[3:0];
        ev.back  = cur_attr[7:4];
        term_events_q.push_back(ev);
    endfunction

    function automatic void push_scroll();
        t_term_event ev;
        ev      = '0;
        ev.kind = KIND_SCROLL;
        term_events_q.push_back(ev);
        cur_row = term_rows;
    endfunction

    // New attribute after an SGR code
    function automatic logic [7:0] sgr_attr(input logic [7:0] a, input logic [7:0] code);
        logic [3:0] f;
        logic [3:0] b;
        logic [7:0] r;
        int         k;
        f = a[3:0];
        b = a[7:4];
        r = a;
        k = int'(code);
        if (k == 0 || k == 28)
            r = ATTR_DEFAULT;
        else if (k == 1 || k == 22) begin
            if (a < ATTR_BRIGHT) r = a + ATTR_BRIGHT;
        end else if (k == 2 || k == 21) begin
            if (a > ATTR_BRIGHT) r = a - ATTR_BRIGHT;
        end else if (k == 7 || k == 27)
            r = {f, b};
        else if (k == 8)
            r = {b, b};
        else if (k >= 30 && k <= 37)
            r = {b, FG_PAL[(k - 30) * 4 +: 4]};
        else if (k == 39)
            r = {b, 4'd7};
        else if (k >= 90 && k <= 97)
            r = {b, BRIGHT_PAL[(k - 90) * 4 +: 4]};
        else if (k >= 40 && k <= 47)
            r = {BG_PAL[(k - 40) * 4 +: 4], f};
        else if (k == 49)
            r = {4'd0, f};
        else if (k >= 100 && k <= 107)
            r = {BRIGHT_PAL[(k - 100) * 4 +: 4], f};
        return r;
    endfunction

    // Printable byte or cursor control in normal text mode
    function automatic void print_char(input logic [7:0] c);
        if ({1'b0, cur_col} + 9'd1 >= {1'b0, term_cols}) begin
            cur_col = 8'd0;
            if (cur_row < term_rows) cur_row = cur_row + 8'd1;
            else push_scroll();
        end
        case (c)
            CH_NL: begin
                if (cur_row >= term_rows) push_scroll();
                else cur_row = cur_row + 8'd1;
                cur_col = 8'd0;
            end
            CH_CR: begin
                cur_col = 8'd0;
            end
            CH_BS: begin
                push_cell(CH_SPACE);
                if (cur_col == 8'd0) begin
                    if (cur_row > 8'd0) cur_row = cur_row - 8'd1;
                end else begin
                    cur_col = cur_col - 8'd1;
                end
            end
            CH_TAB: begin
                // 8-bit column wraps to 0, which also ends the tab
                do begin
                    push_cell(CH_SPACE);
                    cur_col = cur_col + 8'd1;
                end while ((cur_col % TAB_STOP) != 0);
            end
            default: begin
                push_cell(c);
                cur_col = cur_col + 8'd1;
            end
        endcase
    endfunction

    // One text byte: parser, then the trailing cursor report
    function automatic void console_step(input logic [7:0] c);
        t_term_event rep;
        int          acc;
        case (parse_st)
            PM_ESC: begin
                if (c == CH_LBRACK) begin
                    parse_st   = PM_CSI;
                    sgr_acc    = 8'd0;
                    num_closed = 1'b0;
                end else begin
                    parse_st = PM_TEXT;
                end
            end
            PM_CSI: begin
                if (c == CH_M) begin
                    cur_attr = sgr_attr(cur_attr, sgr_acc);
                    parse_st = PM_TEXT;
                end else if (!num_closed && c >= CH_ZERO && c <= CH_NINE) begin
                    acc     = int'(sgr_acc) * 10 + int'(c) - int'(CH_ZERO);
                    sgr_acc = (acc > 255) ? 8'd255 : acc[7:0];
                end else begin
                    num_closed = 1'b1;
                end
            end
            default: begin
                parse_st = PM_TEXT;
                if (c == CH_ESC) parse_st = PM_ESC;
                else if (c != CH_NUL) print_char(c);
            end
        endcase
        rep      = '0;
        rep.kind = KIND_REPORT;
        rep.col  = cur_col;
        rep.row  = cur_row;
        rep.last = 1'b1;
        term_events_q.push_back(rep);
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.text_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
        console_step(b);
    endtask

    // Wait until every expected event is back and the block is quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        while (term_events_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] last_row);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COLUMNS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROWS;
        i_cfg_data <= last_row;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        term_cols  = cols;
        term_rows  = last_row;
        geometries++;
    endtask

    function automatic int pick_sgr_code();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return $urandom_range(0, 8);
            1: return 21 + $urandom_range(0, 7);
            2, 8: return $urandom_range(30, 39);
            3: return $urandom_range(40, 49);
            4: return $urandom_range(90, 97);
            5: return $urandom_range(100, 107);
            6: return $urandom_range(0, 255);
            default: return $urandom_range(256, 9999);
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(32, 126));
        if (r < 85) begin
            case ($urandom_range(0, 4))
                0: return CH_NL;
                1: return CH_CR;
                2: return CH_BS;
                3: return CH_TAB;
                default: return CH_NUL;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One random piece of the stream: mostly well-formed text and SGR escapes
    task automatic send_chunk();
        int    pick;
        int    n;
        int    k;
        string digits;
        logic [7:0] junk;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            if ($urandom_range(0, 7) != 0) begin
                digits = $sformatf("%0d", pick_sgr_code());
                for (k = 0; k < digits.len(); k++) send_byte(digits[k]);
            end
            if ($urandom_range(0, 5) == 0) begin
                junk = 8'($urandom_range(0, 255));
                if (junk == CH_M) junk = 8'h3B;
                send_byte(junk);
                if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
            send_byte(CH_M);
        end else if (pick < 35) begin
            // broken escape
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 80) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) send_byte(pick_text_byte());
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // Output side: random back-pressure and one long hold-off
    // ---------------------------------------------------------------
    initial begin : result_sink
        int n;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic note_mismatch(input string what, input t_term_event want,
                                 input t_term_event got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: exp kind=%0d glyph=%h col=%0d row=%0d fore=%0d back=%0d last=%0d",
                     what, want.kind, want.glyph, want.col, want.row, want.fore,
                     want.back, want.last);
        if (mismatches <= 10)
            $display("           got kind=%0d glyph=%h col=%0d row=%0d fore=%0d back=%0d last=%0d",
                     got.kind, got.glyph, got.col, got.row, got.fore, got.back, got.last);
    endtask

    // Compare each result with the oldest expected event
    always @(posedge i_clk) begin : result_check
        t_term_event got;
        t_term_event want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind  = t_kind'(out_if.kind);
            got.glyph = out_if.glyph;
            got.col   = out_if.col;
            got.row   = out_if.row;
            got.fore  = out_if.fore;
            got.back  = out_if.back;
            got.last  = out_if.last;
            case (got.kind)
                KIND_CELL:   cells_seen++;
                KIND_SCROLL: scrolls_seen++;
                default:     reports_seen++;
            endcase
            if (term_events_q.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = term_events_q.pop_front();
                if (got.kind !== want.kind || got.glyph !== want.glyph ||
                    got.col !== want.col || got.row !== want.row ||
                    got.fore !== want.fore || got.back !== want.back ||
                    got.last !== want.last)
                    note_mismatch("field", want, got);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        int i;
        int ph;
        int phase_end;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_COLUMNS;
        i_cfg_data      = 8'd0;
        in_if.valid     = 1'b0;
        in_if.text_byte = 8'd0;
        term_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset geometry
        for (i = 0; i < DIR_ROWS; i++) begin
            send_byte(DIR_TBL[i].text);
            if (DIR_TBL[i].typed) begin
                term_events_q[term_events_q.size() - 1].col = DIR_TBL[i].col;
                term_events_q[term_events_q.size() - 1].row = DIR_TBL[i].row;
            end
        end
        settle();

        // Random phases, one geometry each
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_geometry(8'(ph_cols[ph]), 8'(ph_rows[ph]));
            if (ph == 0) hold_len = HOLD_CYCLES;
            if (ph == NUM_PHASES - 1) idle_en = 1'b0;
            // Widest line: tab stops up to the end, last tab wraps the column
            if (ph_cols[ph] == 255) begin
                send_byte(CH_CR);
                for (i = 0; i < 63; i++) send_byte(CH_TAB);
                send_byte(8'h61);
                send_byte(CH_TAB);
            end
            phase_end = bytes_sent + ph_items[ph];
            while (bytes_sent < phase_end) send_chunk();
            settle();
        end

        if (term_events_q.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", term_events_q.size());
        end
        $display("Sent %0d text bytes over %0d screen geometries, incl. long output hold-off.",
                 bytes_sent, geometries);
        $display("Checked %0d cell writes, %0d scrolls, %0d cursor reports; %0d mismatches.",
                 cells_seen, scrolls_seen, reports_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
